// ===== hw/rtl/mlfc_pkg.sv =====
// Shared types and constants for the motion and lux controlled LED fader.
`default_nettype none
package mlfc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_FADE_STEP       = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_LUX_HYSTERESIS  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_AVERAGE_LOG2    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TICKS_PER_10MS  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TICKS_PER_100MS = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_TICKS_PER_SEC   = 3'd5;

  // Lamp modes as shown on lamp_state.
  localparam logic [1:0] MODE_OFF      = 2'd0;
  localparam logic [1:0] MODE_FADE_IN  = 2'd1;
  localparam logic [1:0] MODE_ON       = 2'd2;
  localparam logic [1:0] MODE_FADE_OUT = 2'd3;

  localparam logic [9:0]  DUTY_MAX      = 10'd1023;
  localparam logic [14:0] ON_TIME_BASE  = 15'd30;
  localparam logic [26:0] ON_TIME_SCALE = 27'd1800;
  localparam logic [2:0]  AVG_LOG2_MAX  = 3'd4;

  // Register defaults after reset.
  localparam logic [9:0]  FADE_STEP_RST     = 10'd4;
  localparam logic [11:0] LUX_HYST_RST      = 12'd100;
  localparam logic [2:0]  AVG_LOG2_RST      = 3'd4;
  localparam logic [15:0] TICKS_10MS_RST    = 16'd10;
  localparam logic [15:0] TICKS_100MS_RST   = 16'd100;
  localparam logic [15:0] TICKS_SECOND_RST  = 16'd1000;

  typedef struct packed {
    logic [9:0]  fade_step;
    logic [11:0] lux_hysteresis;
    logic [2:0]  average_log2;
    logic [15:0] ticks_per_10ms;
    logic [15:0] ticks_per_100ms;
    logic [15:0] ticks_per_second;
  } mlfc_cfg_t;

  typedef struct packed {
    logic        motion_a;
    logic        motion_b;
    logic [11:0] ambient_lux_sample;
    logic [11:0] lux_setting_sample;
    logic [11:0] on_time_sample;
    logic [11:0] brightness_sample;
  } mlfc_item_t;

  // On-time and countdown keep 15 bits: a block closed early after the
  // averaging size shrinks can yield an average well above 4095.
  typedef struct packed {
    logic [15:0]      div_10ms_count;
    logic [15:0]      div_100ms_count;
    logic [15:0]      div_second_count;
    logic [3:0][15:0] sample_sums;
    logic [4:0]       sample_count;
    logic [9:0]       duty_target;
    logic [14:0]      on_time_target;
    logic [9:0]       duty_now;
    logic [1:0]       lamp_mode;
    logic [14:0]      countdown;
    logic             lux_ok;
  } mlfc_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mlfc_in_if.sv =====
// Input channel: one 1 ms tick with motion bits and four ADC samples.
`default_nettype none
interface mlfc_in_if;
  logic        valid;
  logic        ready;
  logic        motion_a;
  logic        motion_b;
  logic [11:0] ambient_lux_sample;
  logic [11:0] lux_setting_sample;
  logic [11:0] on_time_sample;
  logic [11:0] brightness_sample;

  modport source (
    output valid, motion_a, motion_b, ambient_lux_sample, lux_setting_sample,
           on_time_sample, brightness_sample,
    input  ready
  );
  modport sink (
    input  valid, motion_a, motion_b, ambient_lux_sample, lux_setting_sample,
           on_time_sample, brightness_sample,
    output ready
  );
endinterface
`default_nettype wire

// ===== hw/rtl/mlfc_out_if.sv =====
// Result channel: PWM duty, lamp state, lux flag and seconds left.
`default_nettype none
interface mlfc_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  pwm_duty;
  logic [1:0]  lamp_state;
  logic        dark_enough;
  logic [10:0] seconds_left;

  modport source (
    output valid, pwm_duty, lamp_state, dark_enough, seconds_left,
    input  ready
  );
  modport sink (
    input  valid, pwm_duty, lamp_state, dark_enough, seconds_left,
    output ready
  );
endinterface
`default_nettype wire

// ===== hw/rtl/mlfc_tick.sv =====
// Next-state logic for one tick: dividers, fade, averaging, motion, countdown.
`default_nettype none
module mlfc_tick
  import mlfc_pkg::*;
(
  input  mlfc_state_t st,
  input  mlfc_item_t  item,
  input  mlfc_cfg_t   cfg,
  output mlfc_state_t st_nxt
);

  logic [15:0]      d10_inc;
  logic [15:0]      d100_inc;
  logic [15:0]      dsec_inc;
  logic             ev10;
  logic             ev100;
  logic             ev1s;
  logic             motion;
  logic [10:0]      duty_up;
  logic [9:0]       duty_up_sat;
  logic [9:0]       duty_dn;
  logic [3:0][15:0] smp;
  logic [3:0][15:0] sums_add;
  logic [4:0]       cnt_add;
  logic [2:0]       lg;
  logic [4:0]       block_size;
  logic             block_done;
  logic [15:0]      avg_amb;
  logic [15:0]      avg_set;
  logic [15:0]      avg_on;
  logic [15:0]      avg_bright;
  logic [26:0]      on_prod;
  logic [14:0]      on_time_new;
  logic [16:0]      amb_ext;
  logic [16:0]      set_ext;
  logic [16:0]      hyst_ext;
  logic             lux_lost;
  logic             lux_back;

  assign d10_inc  = st.div_10ms_count + 16'd1;
  assign d100_inc = st.div_100ms_count + 16'd1;
  assign dsec_inc = st.div_second_count + 16'd1;
  assign ev10  = (d10_inc == cfg.ticks_per_10ms);
  assign ev100 = (d100_inc == cfg.ticks_per_100ms);
  assign ev1s  = (dsec_inc == cfg.ticks_per_second);
  assign motion = item.motion_a | item.motion_b;

  assign duty_up     = {1'b0, st.duty_now} + {1'b0, cfg.fade_step};
  assign duty_up_sat = duty_up[10] ? DUTY_MAX : duty_up[9:0];
  assign duty_dn     = (st.duty_now > cfg.fade_step) ? (st.duty_now - cfg.fade_step) : 10'd0;

  assign smp[0] = {4'd0, item.ambient_lux_sample};
  assign smp[1] = {4'd0, item.lux_setting_sample};
  assign smp[2] = {4'd0, item.on_time_sample};
  assign smp[3] = {4'd0, item.brightness_sample};

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sums_add[i] = st.sample_sums[i] + smp[i];
    end
  end

  assign cnt_add    = st.sample_count + 5'd1;
  assign lg         = (cfg.average_log2 > AVG_LOG2_MAX) ? AVG_LOG2_MAX : cfg.average_log2;
  assign block_size = 5'd1 << lg;
  assign block_done = (cnt_add >= block_size);

  assign avg_amb    = sums_add[0] >> lg;
  assign avg_set    = sums_add[1] >> lg;
  assign avg_on     = sums_add[2] >> lg;
  assign avg_bright = sums_add[3] >> lg;

  assign on_prod     = {11'd0, avg_on} * ON_TIME_SCALE;
  assign on_time_new = on_prod[26:12] + ON_TIME_BASE;

  assign amb_ext  = {1'b0, avg_amb};
  assign set_ext  = {1'b0, avg_set};
  assign hyst_ext = {5'd0, cfg.lux_hysteresis};
  assign lux_lost = (amb_ext > set_ext + hyst_ext);
  assign lux_back = (amb_ext + hyst_ext < set_ext);

  // The events apply in a fixed order within a tick; the motion and countdown
  // steps read what the earlier ones left in st_nxt.
  always_comb begin
    st_nxt = st;
    st_nxt.div_10ms_count   = ev10  ? 16'd0 : d10_inc;
    st_nxt.div_100ms_count  = ev100 ? 16'd0 : d100_inc;
    st_nxt.div_second_count = ev1s  ? 16'd0 : dsec_inc;

    if (st.lamp_mode == MODE_FADE_IN) begin
      if (st.duty_now < st.duty_target) begin
        st_nxt.duty_now = duty_up_sat;
      end else begin
        st_nxt.lamp_mode = MODE_ON;
      end
    end else if (st.lamp_mode == MODE_FADE_OUT) begin
      if (st.duty_now != 10'd0) begin
        st_nxt.duty_now = duty_dn;
      end else begin
        st_nxt.lamp_mode = MODE_OFF;
      end
    end

    if (ev10) begin
      if (block_done) begin
        st_nxt.sample_sums    = '0;
        st_nxt.sample_count   = 5'd0;
        st_nxt.duty_target    = avg_bright[11:2];
        st_nxt.on_time_target = on_time_new;
        if (st.lux_ok) begin
          if (lux_lost) begin
            st_nxt.lux_ok    = 1'b0;
            st_nxt.lamp_mode = MODE_FADE_OUT;
          end
        end else if (lux_back) begin
          st_nxt.lux_ok = 1'b1;
        end
      end else begin
        st_nxt.sample_sums  = sums_add;
        st_nxt.sample_count = cnt_add;
      end
    end

    if (ev100 && motion) begin
      if (st_nxt.lamp_mode == MODE_ON) begin
        st_nxt.countdown = st_nxt.on_time_target;
      end else if ((st_nxt.lamp_mode inside {MODE_OFF, MODE_FADE_OUT}) && st_nxt.lux_ok) begin
        st_nxt.countdown = st_nxt.on_time_target;
        st_nxt.lamp_mode = MODE_FADE_IN;
      end
    end

    if (ev1s && (st_nxt.lamp_mode == MODE_ON)) begin
      if (st_nxt.countdown != 15'd0) begin
        st_nxt.countdown = st_nxt.countdown - 15'd1;
      end
      if (st_nxt.countdown == 15'd0) begin
        st_nxt.lamp_mode = MODE_FADE_OUT;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/motion_lux_led_fade_controller.sv =====
// Top level of the motion and lux controlled LED fader.
//
//   channel  direction  payload                                         beat
//   in_ch    sink       motion_a/b, four 12-bit ADC samples             one 1 ms tick
//   out_ch   source     pwm_duty, lamp_state, dark_enough, seconds_left one per tick
//   cfg_*    write      cfg_index selects register, cfg_data value      one register
//
// One beat is accepted per clock while back-pressure on out_ch does not stall the input.
// The tick is captured in an input register, then one pass of next-state logic
// updates the controller state and the result register together.
// Back-pressure on out_ch stalls both stages; the input register keeps accepting
// while it is empty or while the result register is free or being taken.
// rst_n is synchronous and active low: state clears, registers take defaults.
`default_nettype none
module motion_lux_led_fade_controller
  import mlfc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  mlfc_in_if.sink                  in_ch,
  mlfc_out_if.source               out_ch,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  mlfc_cfg_t   cfg_r;
  mlfc_state_t state_r;
  mlfc_state_t state_nxt;
  mlfc_item_t  item_r;
  logic        item_valid_r;
  logic        out_valid_r;
  logic [9:0]  pwm_duty_r;
  logic [1:0]  lamp_state_r;
  logic        dark_enough_r;
  logic [10:0] seconds_left_r;
  logic        advance;
  logic        in_ready;

  assign advance  = item_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ready = !item_valid_r || advance;

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.pwm_duty     = pwm_duty_r;
  assign out_ch.lamp_state   = lamp_state_r;
  assign out_ch.dark_enough  = dark_enough_r;
  assign out_ch.seconds_left = seconds_left_r;

  mlfc_tick u_tick (
    .st     (state_r),
    .item   (item_r),
    .cfg    (cfg_r),
    .st_nxt (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fade_step        <= FADE_STEP_RST;
      cfg_r.lux_hysteresis   <= LUX_HYST_RST;
      cfg_r.average_log2     <= AVG_LOG2_RST;
      cfg_r.ticks_per_10ms   <= TICKS_10MS_RST;
      cfg_r.ticks_per_100ms  <= TICKS_100MS_RST;
      cfg_r.ticks_per_second <= TICKS_SECOND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FADE_STEP:       cfg_r.fade_step        <= cfg_data[9:0];
        CFG_LUX_HYSTERESIS:  cfg_r.lux_hysteresis   <= cfg_data[11:0];
        CFG_AVERAGE_LOG2:    cfg_r.average_log2     <= cfg_data[2:0];
        CFG_TICKS_PER_10MS:  cfg_r.ticks_per_10ms   <= cfg_data;
        CFG_TICKS_PER_100MS: cfg_r.ticks_per_100ms  <= cfg_data;
        CFG_TICKS_PER_SEC:   cfg_r.ticks_per_second <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      state_r      <= '0;
    end else begin
      if (in_ready) begin
        item_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      item_r.motion_a           <= in_ch.motion_a;
      item_r.motion_b           <= in_ch.motion_b;
      item_r.ambient_lux_sample <= in_ch.ambient_lux_sample;
      item_r.lux_setting_sample <= in_ch.lux_setting_sample;
      item_r.on_time_sample     <= in_ch.on_time_sample;
      item_r.brightness_sample  <= in_ch.brightness_sample;
    end
    if (advance) begin
      pwm_duty_r     <= state_nxt.duty_now;
      lamp_state_r   <= state_nxt.lamp_mode;
      dark_enough_r  <= state_nxt.lux_ok;
      seconds_left_r <= state_nxt.countdown[10:0];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/mlfc_checker.sv =====
// Port-level checks for the LED fader, bound to the top level.
`default_nettype none
module mlfc_checker
  import mlfc_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [9:0]  pwm_duty,
  input wire logic [1:0]  lamp_state,
  input wire logic        dark_enough,
  input wire logic [10:0] seconds_left
);

  logic prev_seen_r;
  logic prev_dark_r;

  // Remember the lux flag of the last delivered beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_seen_r <= 1'b0;
      prev_dark_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      prev_seen_r <= 1'b1;
      prev_dark_r <= dark_enough;
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pwm_duty) && $stable(lamp_state)
      && $stable(dark_enough) && $stable(seconds_left))
    else $error("stalled result beat changed");

  a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while result side is free");

  a_off_means_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && lamp_state == MODE_OFF |-> pwm_duty == 10'd0)
    else $error("lamp off with nonzero duty");

  a_lux_loss_fades_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && prev_seen_r && prev_dark_r && !dark_enough |-> lamp_state == MODE_FADE_OUT)
    else $error("lux loss did not start a fade out");

endmodule

bind motion_lux_led_fade_controller mlfc_checker u_mlfc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .pwm_duty     (out_ch.pwm_duty),
  .lamp_state   (out_ch.lamp_state),
  .dark_enough  (out_ch.dark_enough),
  .seconds_left (out_ch.seconds_left)
);
`default_nettype wire
